// ===== hw/rtl/mbsb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbsb_pkg
// Shared constants, register indexes and controller/datapath types for the
// max-blend sprite blitter.
// ----------------------------------------------------------------------------
package mbsb_pkg;

  // Height map is MAP_DIM x MAP_DIM tiles
  localparam int MAP_DIM   = 512;
  localparam int MAP_AW    = $clog2(MAP_DIM);
  localparam int ADDR_W    = 2 * MAP_AW;
  localparam int MAP_DEPTH = MAP_DIM * MAP_DIM;

  // Field widths
  localparam int OP_W      = 2;
  localparam int COORD_W   = 9;
  localparam int HEIGHT_W  = 8;
  localparam int SIZE_W    = 10;
  localparam int FEAT_W    = 8;
  localparam int CNT_W     = 8;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 3;

  // Axis modulus and the dividend of the remainder unit
  localparam int MOD_W     = 9;
  localparam int DVD_W     = MOD_W + 1;
  localparam int DIV_STEPS = DVD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Opcodes; the spare code behaves as a read
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_BLEND = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FEAT_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FEAT_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR      = 3'd7;

  // Register reset values
  localparam logic [SIZE_W-1:0] MAP_SIZE_RST = 10'd384;
  localparam logic [FEAT_W-1:0] FEAT_RST     = 8'd1;

  // Operand select of the shared remainder unit
  typedef enum logic [1:0] {
    MSEL_OX   = 2'd0,
    MSEL_OY   = 2'd1,
    MSEL_STEP = 2'd2
  } mod_sel_t;

  typedef struct packed {
    logic     load_item;
    logic     mod_start;
    mod_sel_t mod_sel;
    logic     cap_ox;
    logic     cap_oy;
    logic     walk_init;
    logic     write_tile;
    logic     mem_read;
    logic     mem_finish;
    logic     step_apply;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic mod_done;
    logic item_blend;
    logic step_mod;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mbsb_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbsb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mbsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mbsb_mod.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbsb_mod
// Bit-serial remainder unit: one restoring step per cycle, result valid in
// the cycle that done is high.
// ----------------------------------------------------------------------------
module mbsb_mod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mbsb_pkg::DVD_W-1:0]  dividend,
  input  logic [mbsb_pkg::MOD_W-1:0]  divisor,
  output logic                        done,
  output logic [mbsb_pkg::MOD_W-1:0]  result
);
  import mbsb_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [MOD_W-1:0]     rem;
  logic [MOD_W-1:0]     rem_next;
  logic [DVD_W-1:0]     dvd;
  logic [MOD_W-1:0]     dvs;
  logic [DVD_W-1:0]     trial;

  always_comb begin
    trial = {rem, dvd[DVD_W-1]};
    if (trial >= {1'b0, dvs}) begin
      rem_next = MOD_W'(trial - {1'b0, dvs});
    end else begin
      rem_next = MOD_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[DVD_W-2:0], 1'b0};
    end
  end

  assign result = rem;

endmodule

`default_nettype wire

// ===== hw/rtl/mbsb_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbsb_dp
// Datapath: configuration registers, sprite walk, remainder unit, height map
// and the result and output registers.
// ----------------------------------------------------------------------------
module mbsb_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mbsb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbsb_pkg::CFG_W-1:0]    cfg_data,
  input  logic [mbsb_pkg::OP_W-1:0]     opcode,
  input  logic [mbsb_pkg::COORD_W-1:0]  tile_x,
  input  logic [mbsb_pkg::COORD_W-1:0]  tile_y,
  input  logic [mbsb_pkg::HEIGHT_W-1:0] value,
  input  logic                          first_pixel,
  input  mbsb_pkg::dp_cmd_t             cmd,
  output mbsb_pkg::dp_status_t          status,
  output logic [mbsb_pkg::COORD_W-1:0]  out_x,
  output logic [mbsb_pkg::COORD_W-1:0]  out_y,
  output logic [mbsb_pkg::HEIGHT_W-1:0] height,
  output logic                          sprite_done
);
  import mbsb_pkg::*;

  // Configuration
  logic [SIZE_W-1:0] map_width;
  logic [SIZE_W-1:0] map_height;
  logic [COORD_W-1:0] origin_x;
  logic [COORD_W-1:0] origin_y;
  logic [FEAT_W-1:0] feature_width;
  logic [FEAT_W-1:0] feature_height;
  logic              transpose_walk;
  logic              mirror_inner;

  // Item held for the length of one operation
  logic [OP_W-1:0]     item_op;
  logic [COORD_W-1:0]  item_x;
  logic [COORD_W-1:0]  item_y;
  logic [HEIGHT_W-1:0] item_val;
  logic                item_first;

  // Walk state
  logic [COORD_W-1:0] walk_x, walk_x_next;
  logic [COORD_W-1:0] walk_y, walk_y_next;
  logic [CNT_W-1:0]   inner_count, inner_count_next;
  logic [CNT_W-1:0]   outer_count, outer_count_next;
  logic [MOD_W-1:0]   ox_mod;
  logic [MOD_W-1:0]   oy_mod;

  // Result waiting for the output register
  logic [COORD_W-1:0]  res_x;
  logic [COORD_W-1:0]  res_y;
  logic [HEIGHT_W-1:0] res_h;
  logic                res_done;

  // Derived sizes
  logic [MOD_W-1:0] xm, ym, fw, fh;
  logic [MOD_W-1:0] inner_c, outer_c, inner_mod, outer_mod;
  logic [MOD_W-1:0] inner_len, outer_len, start_base, inner_start;
  logic [MOD_W:0]   start_sum;
  logic [MOD_W-1:0] rs_x, rs_y;
  logic [MOD_W-1:0] inner_new;
  logic             inner_more, outer_more, last_pixel;

  // Remainder unit
  logic [DVD_W-1:0] mod_dvd, step_dvd;
  logic [MOD_W-1:0] mod_dvs, step_dvs;
  logic             mod_done;
  logic [MOD_W-1:0] mod_res;

  // Memory
  logic                is_blend;
  logic [ADDR_W-1:0]   walk_addr, tile_addr;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [HEIGHT_W-1:0] ram_wdata, ram_rdata, blend_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width      <= MAP_SIZE_RST;
      map_height     <= MAP_SIZE_RST;
      origin_x       <= '0;
      origin_y       <= '0;
      feature_width  <= FEAT_RST;
      feature_height <= FEAT_RST;
      transpose_walk <= 1'b0;
      mirror_inner   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAP_WIDTH:   map_width      <= cfg_data[SIZE_W-1:0];
        REG_MAP_HEIGHT:  map_height     <= cfg_data[SIZE_W-1:0];
        REG_ORIGIN_X:    origin_x       <= cfg_data[COORD_W-1:0];
        REG_ORIGIN_Y:    origin_y       <= cfg_data[COORD_W-1:0];
        REG_FEAT_WIDTH:  feature_width  <= cfg_data[FEAT_W-1:0];
        REG_FEAT_HEIGHT: feature_height <= cfg_data[FEAT_W-1:0];
        REG_TRANSPOSE:   transpose_walk <= cfg_data[0];
        REG_MIRROR:      mirror_inner   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp sizes, then take modulus and sprite extent per axis
  always_comb begin
    if (map_width < SIZE_W'(3)) begin
      xm = MOD_W'(2);
    end else if (map_width > SIZE_W'(MAP_DIM)) begin
      xm = MOD_W'(MAP_DIM - 1);
    end else begin
      xm = MOD_W'(map_width - 1'b1);
    end
    if (map_height < SIZE_W'(3)) begin
      ym = MOD_W'(2);
    end else if (map_height > SIZE_W'(MAP_DIM)) begin
      ym = MOD_W'(MAP_DIM - 1);
    end else begin
      ym = MOD_W'(map_height - 1'b1);
    end
    if (feature_width == '0) begin
      fw = MOD_W'(1);
    end else if (MOD_W'(feature_width) > xm) begin
      fw = xm;
    end else begin
      fw = MOD_W'(feature_width);
    end
    if (feature_height == '0) begin
      fh = MOD_W'(1);
    end else if (MOD_W'(feature_height) > ym) begin
      fh = ym;
    end else begin
      fh = MOD_W'(feature_height);
    end
  end

  // Inner and outer axis views of the walk
  always_comb begin
    if (transpose_walk) begin
      inner_c    = walk_y;
      outer_c    = walk_x;
      inner_mod  = ym;
      outer_mod  = xm;
      inner_len  = fh;
      outer_len  = fw;
      start_base = oy_mod;
    end else begin
      inner_c    = walk_x;
      outer_c    = walk_y;
      inner_mod  = xm;
      outer_mod  = ym;
      inner_len  = fw;
      outer_len  = fh;
      start_base = ox_mod;
    end
    // base < mod and extent <= mod, so one subtract wraps the far edge
    start_sum = {1'b0, start_base} + {1'b0, inner_len} - 1'b1;
    if (!mirror_inner) begin
      inner_start = start_base;
    end else if (start_sum >= {1'b0, inner_mod}) begin
      inner_start = MOD_W'(start_sum - {1'b0, inner_mod});
    end else begin
      inner_start = MOD_W'(start_sum);
    end
    if (transpose_walk) begin
      rs_x = ox_mod;
      rs_y = inner_start;
    end else begin
      rs_x = inner_start;
      rs_y = oy_mod;
    end
    inner_more = (MOD_W'(inner_count) + 1'b1) < inner_len;
    outer_more = (MOD_W'(outer_count) + 1'b1) < outer_len;
    last_pixel = !inner_more && !outer_more;
    if (inner_more) begin
      step_dvd = mirror_inner ? {1'b0, inner_c} : ({1'b0, inner_c} + 1'b1);
      step_dvs = inner_mod;
    end else begin
      step_dvd = {1'b0, outer_c} + 1'b1;
      step_dvs = outer_mod;
    end
    if (!mirror_inner) begin
      inner_new = mod_res;
    end else if (mod_res == '0) begin
      inner_new = inner_mod - 1'b1;
    end else begin
      inner_new = mod_res - 1'b1;
    end
  end

  always_comb begin
    case (cmd.mod_sel)
      MSEL_OY: begin
        mod_dvd = {1'b0, origin_y};
        mod_dvs = ym;
      end
      MSEL_STEP: begin
        mod_dvd = step_dvd;
        mod_dvs = step_dvs;
      end
      default: begin
        mod_dvd = {1'b0, origin_x};
        mod_dvs = xm;
      end
    endcase
  end

  mbsb_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (mod_dvd),
    .divisor  (mod_dvs),
    .done     (mod_done),
    .result   (mod_res)
  );

  always_comb begin
    walk_x_next      = walk_x;
    walk_y_next      = walk_y;
    inner_count_next = inner_count;
    outer_count_next = outer_count;
    if ((cmd.walk_init && item_first) || (cmd.step_apply && last_pixel)) begin
      walk_x_next      = rs_x;
      walk_y_next      = rs_y;
      inner_count_next = '0;
      outer_count_next = '0;
    end else if (cmd.step_apply && inner_more) begin
      inner_count_next = inner_count + 1'b1;
      if (transpose_walk) begin
        walk_y_next = inner_new;
      end else begin
        walk_x_next = inner_new;
      end
    end else if (cmd.step_apply) begin
      inner_count_next = '0;
      outer_count_next = outer_count + 1'b1;
      if (transpose_walk) begin
        walk_x_next = mod_res;
        walk_y_next = inner_start;
      end else begin
        walk_x_next = inner_start;
        walk_y_next = mod_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_x      <= '0;
      walk_y      <= '0;
      inner_count <= '0;
      outer_count <= '0;
    end else begin
      walk_x      <= walk_x_next;
      walk_y      <= walk_y_next;
      inner_count <= inner_count_next;
      outer_count <= outer_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_op    <= opcode;
      item_x     <= tile_x;
      item_y     <= tile_y;
      item_val   <= value;
      item_first <= first_pixel;
    end
    if (cmd.cap_ox) begin
      ox_mod <= mod_res;
    end
    if (cmd.cap_oy) begin
      oy_mod <= mod_res;
    end
  end

  // Height map
  assign is_blend  = (item_op == OP_BLEND);
  assign walk_addr = {walk_y[MAP_AW-1:0], walk_x[MAP_AW-1:0]};
  assign tile_addr = {item_y[MAP_AW-1:0], item_x[MAP_AW-1:0]};
  assign blend_h   = (item_val > ram_rdata) ? item_val : ram_rdata;
  assign ram_we    = cmd.write_tile || (cmd.mem_finish && is_blend);
  assign ram_waddr = cmd.write_tile ? tile_addr : walk_addr;
  assign ram_wdata = cmd.write_tile ? item_val : blend_h;
  assign ram_raddr = is_blend ? walk_addr : tile_addr;

  mbsb_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.mem_read),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.write_tile) begin
      res_x    <= item_x;
      res_y    <= item_y;
      res_h    <= item_val;
      res_done <= 1'b0;
    end else if (cmd.mem_finish && is_blend) begin
      res_x    <= walk_x;
      res_y    <= walk_y;
      res_h    <= blend_h;
      res_done <= last_pixel;
    end else if (cmd.mem_finish) begin
      res_x    <= item_x;
      res_y    <= item_y;
      res_h    <= ram_rdata;
      res_done <= 1'b0;
    end
    if (cmd.load_out) begin
      out_x       <= res_x;
      out_y       <= res_y;
      height      <= res_h;
      sprite_done <= res_done;
    end
  end

  assign status.mod_done   = mod_done;
  assign status.item_blend = is_blend;
  assign status.step_mod   = !last_pixel;

endmodule

`default_nettype wire

// ===== hw/rtl/mbsb_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbsb_ctrl
// Controller: sequences one item through the datapath and owns both
// handshakes.
// ----------------------------------------------------------------------------
module mbsb_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [mbsb_pkg::OP_W-1:0] opcode,
  output logic                      out_valid,
  input  logic                      out_stall,
  input  mbsb_pkg::dp_status_t      status,
  output mbsb_pkg::dp_cmd_t         cmd
);
  import mbsb_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_WRITE    = 9'b000000010,
    S_OX       = 9'b000000100,
    S_OY       = 9'b000001000,
    S_WALK     = 9'b000010000,
    S_RD_ISSUE = 9'b000100000,
    S_RD_DATA  = 9'b001000000,
    S_STEP     = 9'b010000000,
    S_FINISH   = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mod_sel = MSEL_OX;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          if (opcode == OP_WRITE) begin
            state_next = S_WRITE;
          end else if (opcode == OP_BLEND) begin
            cmd.mod_start = 1'b1;
            state_next    = S_OX;
          end else begin
            state_next = S_RD_ISSUE;
          end
        end
      end
      S_WRITE: begin
        cmd.write_tile = 1'b1;
        state_next     = S_FINISH;
      end
      S_OX: begin
        if (status.mod_done) begin
          cmd.cap_ox    = 1'b1;
          cmd.mod_start = 1'b1;
          cmd.mod_sel   = MSEL_OY;
          state_next    = S_OY;
        end
      end
      S_OY: begin
        cmd.mod_sel = MSEL_OY;
        if (status.mod_done) begin
          cmd.cap_oy = 1'b1;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk_init = 1'b1;
        state_next    = S_RD_ISSUE;
      end
      S_RD_ISSUE: begin
        cmd.mem_read = 1'b1;
        state_next   = S_RD_DATA;
      end
      S_RD_DATA: begin
        cmd.mem_finish = 1'b1;
        cmd.mod_sel    = MSEL_STEP;
        if (!status.item_blend) begin
          state_next = S_FINISH;
        end else if (status.step_mod) begin
          cmd.mod_start = 1'b1;
          state_next    = S_STEP;
        end else begin
          // last pixel: restart the walk, no remainder needed
          cmd.step_apply = 1'b1;
          state_next     = S_FINISH;
        end
      end
      S_STEP: begin
        cmd.mod_sel = MSEL_STEP;
        if (status.mod_done) begin
          cmd.step_apply = 1'b1;
          state_next     = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the output register is free or being emptied
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/max_blend_sprite_blit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// max_blend_sprite_blit
// Height-map store with tile write/read and a max-blend sprite walk in four
// orders (row-major, mirrored, transposed, transposed mirrored).
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | into      | in_valid / in_stall   | opcode tile_x tile_y value first_pixel
//  out     | out of    | out_valid / out_stall | out_x out_y height sprite_done
//  cfg     | into      | cfg_we                | cfg_index cfg_data
//
// One item at a time; the blend time is set by the bit-serial remainder unit,
// used for both origins and for the walk step (the walk step is skipped on
// the last pixel of a sprite).
// The next item is taken while a result still waits in the output register.
// Reset clears the walk and restores register defaults; map contents are
// undefined until written, so there is no clearing pass.
// ----------------------------------------------------------------------------
module max_blend_sprite_blit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mbsb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbsb_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mbsb_pkg::OP_W-1:0]      opcode,
  input  logic [mbsb_pkg::COORD_W-1:0]   tile_x,
  input  logic [mbsb_pkg::COORD_W-1:0]   tile_y,
  input  logic [mbsb_pkg::HEIGHT_W-1:0]  value,
  input  logic                           first_pixel,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mbsb_pkg::COORD_W-1:0]   out_x,
  output logic [mbsb_pkg::COORD_W-1:0]   out_y,
  output logic [mbsb_pkg::HEIGHT_W-1:0]  height,
  output logic                           sprite_done
);
  import mbsb_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  mbsb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mbsb_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .opcode      (opcode),
    .tile_x      (tile_x),
    .tile_y      (tile_y),
    .value       (value),
    .first_pixel (first_pixel),
    .cmd         (cmd),
    .status      (status),
    .out_x       (out_x),
    .out_y       (out_y),
    .height      (height),
    .sprite_done (sprite_done)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/mbsb_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbsb_sva
// Port-level checks on the blitter, bound to the top level.
// ----------------------------------------------------------------------------
module mbsb_sva (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [mbsb_pkg::COORD_W-1:0]   out_x,
  input logic [mbsb_pkg::COORD_W-1:0]   out_y,
  input logic [mbsb_pkg::HEIGHT_W-1:0]  height,
  input logic                           sprite_done
);

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat present after reset");

  // An accepted item keeps the input side stalled, so no beat is taken right behind it
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (in_stall ##1 in_stall))
    else $error("input beat accepted while an item is in progress");

  // A result is loaded only at the end of an item, never from idle
  a_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("output beat appeared without an item in progress");

  // A stalled output beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_x) && $stable(out_y)
      && $stable(height) && $stable(sprite_done)))
    else $error("stalled output beat changed");

endmodule

bind max_blend_sprite_blit mbsb_sva u_mbsb_sva (.*);

`default_nettype wire

// ===== dv/mbsb_checker.sv =====
// ----------------------------------------------------------------------------
// mbsb_checker
// Watches the register port and both beat channels of the sprite blitter.
// Keeps its own height map, walk position and register copy. Works out the
// result of every accepted input beat and compares it, field by field, with
// the output beats in order.
// ----------------------------------------------------------------------------
module mbsb_checker
  import mbsb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [OP_W-1:0]      opcode,
  input  logic [COORD_W-1:0]   tile_x,
  input  logic [COORD_W-1:0]   tile_y,
  input  logic [HEIGHT_W-1:0]  value,
  input  logic                 first_pixel,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [COORD_W-1:0]   out_x,
  input  logic [COORD_W-1:0]   out_y,
  input  logic [HEIGHT_W-1:0]  height,
  input  logic                 sprite_done,
  output int                   mismatches,
  output int                   outstanding
);

  typedef struct packed {
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [HEIGHT_W-1:0] h;
    logic                done;
  } tile_result_t;

  tile_result_t        tile_results_due[$];
  logic [HEIGHT_W-1:0] tile_heights [MAP_DEPTH];

  // walk position and progress through the sprite
  int unsigned cur_x, cur_y, inner_n, outer_n;
  // register copy
  int unsigned width_reg, height_reg, orig_x, orig_y, feat_w, feat_h;
  bit          transposed, mirrored;

  function automatic int unsigned wrap_of(int unsigned size);
    if (size < 3) size = 3;
    if (size > MAP_DIM) size = MAP_DIM;
    return size - 1;
  endfunction

  function automatic int unsigned span(int unsigned f, int unsigned m);
    if (f < 1) f = 1;
    if (f > m) f = m;
    return f;
  endfunction

  function automatic void walk_lengths(output int unsigned ilen, output int unsigned olen);
    int unsigned fw, fh;
    fw = span(feat_w, wrap_of(width_reg));
    fh = span(feat_h, wrap_of(height_reg));
    ilen = transposed ? fh : fw;
    olen = transposed ? fw : fh;
  endfunction

  // first coordinate on the inner axis; the far edge when mirrored
  function automatic int unsigned row_start();
    int unsigned m, o, len;
    m   = transposed ? wrap_of(height_reg) : wrap_of(width_reg);
    o   = (transposed ? orig_y : orig_x) % m;
    len = transposed ? span(feat_h, m) : span(feat_w, m);
    return mirrored ? (o + len - 1) % m : o;
  endfunction

  function automatic void rewind_walk();
    inner_n = 0;
    outer_n = 0;
    if (transposed) begin
      cur_x = orig_x % wrap_of(width_reg);
      cur_y = row_start();
    end else begin
      cur_y = orig_y % wrap_of(height_reg);
      cur_x = row_start();
    end
  endfunction

  function automatic int unsigned nudge(int unsigned c, int unsigned m, bit back);
    return back ? (c % m + m - 1) % m : (c + 1) % m;
  endfunction

  function automatic void step_walk();
    int unsigned xm, ym, ilen, olen;
    xm = wrap_of(width_reg);
    ym = wrap_of(height_reg);
    walk_lengths(ilen, olen);
    if (inner_n + 1 < ilen) begin
      inner_n++;
      if (transposed) cur_y = nudge(cur_y, ym, mirrored);
      else cur_x = nudge(cur_x, xm, mirrored);
    end else if (outer_n + 1 < olen) begin
      inner_n = 0;
      outer_n++;
      if (transposed) begin
        cur_x = nudge(cur_x, xm, 1'b0);
        cur_y = row_start();
      end else begin
        cur_y = nudge(cur_y, ym, 1'b0);
        cur_x = row_start();
      end
    end else begin
      rewind_walk();
    end
  endfunction

  function automatic tile_result_t blit_result(logic [OP_W-1:0] op, logic [COORD_W-1:0] tx,
                                               logic [COORD_W-1:0] ty, logic [HEIGHT_W-1:0] v,
                                               logic restart);
    tile_result_t r;
    int unsigned  ilen, olen;
    r.done = 1'b0;
    case (op)
      OP_WRITE: begin
        r.x = tx;
        r.y = ty;
        r.h = v;
        tile_heights[{ty, tx}] = v;
      end
      OP_BLEND: begin
        if (restart) rewind_walk();
        r.x = cur_x[COORD_W-1:0];
        r.y = cur_y[COORD_W-1:0];
        r.h = (v > tile_heights[{r.y, r.x}]) ? v : tile_heights[{r.y, r.x}];
        tile_heights[{r.y, r.x}] = r.h;
        walk_lengths(ilen, olen);
        r.done = (inner_n + 1 >= ilen) && (outer_n + 1 >= olen);
        step_walk();
      end
      default: begin
        // read, and the spare code behaving as one
        r.x = tx;
        r.y = ty;
        r.h = tile_heights[{ty, tx}];
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    tile_result_t want;
    if (rst) begin
      tile_results_due.delete();
      cur_x       = 0;
      cur_y       = 0;
      inner_n     = 0;
      outer_n     = 0;
      width_reg   = MAP_SIZE_RST;
      height_reg  = MAP_SIZE_RST;
      orig_x      = 0;
      orig_y      = 0;
      feat_w      = FEAT_RST;
      feat_h      = FEAT_RST;
      transposed  = 1'b0;
      mirrored    = 1'b0;
      mismatches  = 0;
      outstanding = 0;
    end else begin
      // retire the oldest expectation before queueing a new one
      if (out_valid && !out_stall) begin
        if (tile_results_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual x %0d y %0d height %0d done %0d",
                   $time, out_x, out_y, height, sprite_done);
        end else begin
          want = tile_results_due.pop_front();
          check_field("out_x", want.x, out_x);
          check_field("out_y", want.y, out_y);
          check_field("height", want.h, height);
          check_field("sprite_done", want.done, sprite_done);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MAP_WIDTH:   width_reg  = cfg_data;
          REG_MAP_HEIGHT:  height_reg = cfg_data;
          REG_ORIGIN_X:    orig_x     = cfg_data[COORD_W-1:0];
          REG_ORIGIN_Y:    orig_y     = cfg_data[COORD_W-1:0];
          REG_FEAT_WIDTH:  feat_w     = cfg_data[FEAT_W-1:0];
          REG_FEAT_HEIGHT: feat_h     = cfg_data[FEAT_W-1:0];
          REG_TRANSPOSE:   transposed = cfg_data[0];
          REG_MIRROR:      mirrored   = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        tile_results_due.push_back(blit_result(opcode, tile_x, tile_y, value, first_pixel));
      outstanding = tile_results_due.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the sprite blitter through directed tile and blend beats, extreme
// and clamped register settings, walk changes in the middle of a sprite and
// random mixed traffic with sender idling and receiver back-pressure.
// Results are checked by mbsb_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import mbsb_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 40;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [OP_W-1:0]      opcode;
  logic [COORD_W-1:0]   tile_x;
  logic [COORD_W-1:0]   tile_y;
  logic [HEIGHT_W-1:0]  value;
  logic                 first_pixel;
  logic                 out_valid;
  logic                 out_stall;
  logic [COORD_W-1:0]   out_x;
  logic [COORD_W-1:0]   out_y;
  logic [HEIGHT_W-1:0]  height;
  logic                 sprite_done;
  int                   mismatches;
  int                   outstanding;

  int hold_left   = 0;
  int stall_left  = 0;
  bit calm        = 1'b0;
  int cycle_count = 0;

  // tiles written so far; reads and blends only ever touch these
  bit          tile_known [MAP_DEPTH];
  int unsigned known_tiles[$];
  int unsigned area_x = 0, area_y = 0;

  // register shadow, used only to size the footprint writes
  int unsigned sh_mw = MAP_SIZE_RST, sh_mh = MAP_SIZE_RST, sh_ox = 0, sh_oy = 0;
  int unsigned sh_fw = FEAT_RST, sh_fh = FEAT_RST;

  int n_blend = 0, n_write = 0, n_read = 0, n_settings = 0;

  max_blend_sprite_blit dut (.*);
  mbsb_checker u_check (.*);

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 60) : $urandom_range(1, 3);
  endfunction

  function automatic logic [HEIGHT_W-1:0] rand_height();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return HEIGHT_W'($urandom);
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic int unsigned axis_wrap(int unsigned size);
    return (size < 3) ? 2 : (size > MAP_DIM) ? MAP_DIM - 1 : size - 1;
  endfunction

  function automatic int unsigned clamp_span(int unsigned f, int unsigned m);
    return (f < 1) ? 1 : (f > m) ? m : f;
  endfunction

  function automatic int unsigned pick_size();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(3, 40);
  endfunction

  // random junk above a narrow register's width
  function automatic logic [CFG_W-1:0] with_junk(int unsigned v, int w);
    logic [CFG_W-1:0] d;
    d = CFG_W'(v);
    if ($urandom_range(0, 3) == 0) d = d | (CFG_W'($urandom) << w);
    return d;
  endfunction

  // receiver: random stalls, plus a long hold when asked for one
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        stall_left = idle_len() - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // offer one beat and hold it until accepted
  task automatic offer(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] x,
                       input logic [COORD_W-1:0] y, input logic [HEIGHT_W-1:0] v,
                       input logic restart);
    int gap;
    gap = (calm || $urandom_range(0, 2) != 0) ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    tile_x      <= x;
    tile_y      <= y;
    value       <= v;
    first_pixel <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (op)
      OP_BLEND: n_blend++;
      OP_WRITE: n_write++;
      default:  n_read++;
    endcase
  endtask

  // hold the sender off until every result is back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic put_tile(input int unsigned x, input int unsigned y,
                          input logic [HEIGHT_W-1:0] v);
    offer(OP_WRITE, COORD_W'(x), COORD_W'(y), v, 1'($urandom));
    if (!tile_known[y * MAP_DIM + x]) begin
      tile_known[y * MAP_DIM + x] = 1'b1;
      known_tiles.push_back(y * MAP_DIM + x);
    end
  endtask

  task automatic read_known();
    int unsigned idx;
    idx = known_tiles[$urandom_range(0, known_tiles.size() - 1)];
    offer(($urandom_range(0, 4) == 0) ? OP_SPARE : OP_READ, COORD_W'(idx % MAP_DIM),
          COORD_W'(idx / MAP_DIM), rand_height(), 1'($urandom));
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAP_WIDTH:   sh_mw = data;
      REG_MAP_HEIGHT:  sh_mh = data;
      REG_ORIGIN_X:    sh_ox = data[COORD_W-1:0];
      REG_ORIGIN_Y:    sh_oy = data[COORD_W-1:0];
      REG_FEAT_WIDTH:  sh_fw = data[FEAT_W-1:0];
      REG_FEAT_HEIGHT: sh_fh = data[FEAT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int unsigned mw, input int unsigned mh,
                           input int unsigned ox, input int unsigned oy,
                           input int unsigned fw, input int unsigned fh,
                           input bit tr, input bit mir);
    drain();
    repeat (4) @(negedge clk);
    set_reg(REG_MAP_WIDTH, CFG_W'(mw));
    set_reg(REG_MAP_HEIGHT, CFG_W'(mh));
    set_reg(REG_ORIGIN_X, with_junk(ox, COORD_W));
    set_reg(REG_ORIGIN_Y, with_junk(oy, COORD_W));
    set_reg(REG_FEAT_WIDTH, with_junk(fw, FEAT_W));
    set_reg(REG_FEAT_HEIGHT, with_junk(fh, FEAT_W));
    set_reg(REG_TRANSPOSE, with_junk(tr, 1));
    set_reg(REG_MIRROR, with_junk(mir, 1));
    n_settings++;
  endtask

  // write every tile the sprite can land on from a fresh start
  task automatic cover_footprint();
    int unsigned xm, ym, fw, fh, x0, y0;
    xm = axis_wrap(sh_mw);
    ym = axis_wrap(sh_mh);
    fw = clamp_span(sh_fw, xm);
    fh = clamp_span(sh_fh, ym);
    x0 = sh_ox % xm;
    y0 = sh_oy % ym;
    for (int unsigned j = 0; j < fh; j++)
      for (int unsigned i = 0; i < fw; i++)
        put_tile((x0 + i) % xm, (y0 + j) % ym, rand_height());
  endtask

  // write the whole wrapped area, so a walk carried over a register
  // change never lands on a blank tile
  task automatic cover_area();
    if (axis_wrap(sh_mw) > area_x) area_x = axis_wrap(sh_mw);
    if (axis_wrap(sh_mh) > area_y) area_y = axis_wrap(sh_mh);
    for (int unsigned y = 0; y < area_y; y++)
      for (int unsigned x = 0; x < area_x; x++)
        if (!tile_known[y * MAP_DIM + x]) put_tile(x, y, rand_height());
  endtask

  task automatic mixed_items(input int count, input bit carry);
    int pick;
    bit restart;
    restart = !carry;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        offer(OP_BLEND, rand_coord(), rand_coord(), rand_height(),
              restart | ($urandom_range(0, 15) == 0));
        restart = 1'b0;
      end else if (pick < 17) begin
        read_known();
      end else begin
        put_tile(rand_coord(), rand_coord(), rand_height());
      end
    end
  endtask

  initial begin
    int unsigned a, b;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = REG_MAP_WIDTH;
    cfg_data    = '0;
    in_valid    = 1'b0;
    opcode      = OP_WRITE;
    tile_x      = '0;
    tile_y      = '0;
    value       = '0;
    first_pixel = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: walk sits on the origin tile, one-pixel sprite
    put_tile(0, 0, 8'd100);
    offer(OP_BLEND, '1, '1, 8'd50, 1'b0);
    offer(OP_BLEND, '0, '0, 8'd200, 1'b0);
    offer(OP_BLEND, rand_coord(), rand_coord(), 8'd0, 1'b1);
    put_tile(MAP_DIM - 1, MAP_DIM - 1, 8'd255);
    offer(OP_READ, '1, '1, 8'd0, 1'b1);
    offer(OP_SPARE, '1, '1, 8'd255, 1'b0);
    put_tile(MAP_DIM - 1, 0, 8'd0);
    put_tile(0, MAP_DIM - 1, 8'd255);
    offer(OP_READ, '1, '0, 8'd0, 1'b0);
    offer(OP_READ, '0, '1, 8'd0, 1'b1);
    offer(OP_BLEND, '0, '1, 8'd255, 1'b1);

    // widest map, wide sprite wrapping past the far edge, no idling
    configure(512, 512, 510, 510, 24, 1, 1'b0, 1'b0);
    cover_footprint();
    calm = 1'b1;
    mixed_items(40, 1'b0);
    calm = 1'b0;

    // tall sprite, transposed and mirrored
    configure(512, 512, 0, 0, 1, 20, 1'b1, 1'b1);
    cover_footprint();
    mixed_items(30, 1'b0);

    // sizes, origins and extents all out of range
    configure(0, 1023, 510, 511, 255, 0, 1'b0, 1'b1);
    cover_footprint();
    mixed_items(30, 1'b0);

    configure(3, 2, 0, 511, 0, 255, 1'b1, 1'b0);
    cover_footprint();
    mixed_items(20, 1'b0);

    // long receiver hold while beats keep coming, then a full drain and more beats
    configure(9, 7, 5, 3, 3, 4, 1'b0, 1'b1);
    cover_footprint();
    hold_left = HOLD_CYCLES;
    mixed_items(15, 1'b0);
    drain();
    mixed_items(15, 1'b0);

    // small maps; the walk carries on across each register change after the first
    for (int p = 0; p < 4; p++) begin
      configure($urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(0, 511),
                $urandom_range(0, 511), $urandom_range(0, 12), $urandom_range(0, 12),
                1'($urandom), 1'($urandom));
      cover_area();
      mixed_items(15, p > 0);
    end

    for (int p = 0; p < 6; p++) begin
      if ($urandom_range(0, 4) == 0) begin
        a = $urandom_range(17, 40);
        b = $urandom_range(0, 2);
      end else begin
        a = $urandom_range(0, 8);
        b = $urandom_range(0, 8);
      end
      if ($urandom_range(0, 1) == 0)
        configure(pick_size(), pick_size(), $urandom_range(0, 511), $urandom_range(0, 511),
                  a, b, 1'($urandom), 1'($urandom));
      else
        configure(pick_size(), pick_size(), $urandom_range(0, 511), $urandom_range(0, 511),
                  b, a, 1'($urandom), 1'($urandom));
      cover_footprint();
      calm = ($urandom_range(0, 4) == 0);
      mixed_items(12, 1'b0);
      calm = 1'b0;
    end

    drain();
    repeat (DRAIN_WAIT) @(negedge clk);
    $display("Covered %0d beats: %0d blends, %0d tile writes, %0d tile reads",
             n_blend + n_write + n_read, n_blend, n_write, n_read);
    $display("Sprite walk run under %0d register settings incl. clamped and carried walks",
             n_settings);
    if (mismatches == 0 && outstanding == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
